FILE: src/packed_edge_record_insert_assert.svh
// ----------------------------------------------------------------------------
// Packed edge record insert - assertion macros
// Shared concurrent check forms for the record store block.
// ----------------------------------------------------------------------------
`ifndef PACKED_EDGE_RECORD_INSERT_ASSERT_SVH
`define PACKED_EDGE_RECORD_INSERT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PEREC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PEREC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/perec_pkg.sv
// ----------------------------------------------------------------------------
// perec_pkg
// Constants, control word layout and microcode ROM for the record store.
// ----------------------------------------------------------------------------
package perec_pkg;

	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 16;
	localparam int USED_W   = 13;

	typedef enum logic [1:0] {
		ST_INS  = 2'd0,
		ST_NEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_REJ  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHKZ, S_SCAN, S_DECIDE, S_INS_CHK, S_SEEK, S_SH_INIT, S_SHIFT,
		S_SH_LAST, S_PUT_TS, S_EMIT, S_APP_CHK, S_APP_ID, S_APP_TS, S_APP_Z,
		S_FULL, S_REJ
	} step_t;

	typedef enum logic [3:0] {
		C_NEVER, C_ALWAYS, C_START, C_ZERO, C_SCAN_END, C_NOT_FOUND,
		C_FULL_INS, C_FULL_APP, C_SEEK_ZERO, C_PTR_AT_J
	} cond_t;

	typedef enum logic [2:0] {
		P_HOLD, P_ZERO, P_AT1, P_LAST, P_INC, P_DEC
	} ptr_op_t;

	typedef enum logic [2:0] {
		W_NONE, W_SHIFT, W_TS_J, W_ID, W_TS, W_ZERO
	} wr_op_t;

	typedef enum logic [1:0] {
		F_HOLD, F_INC1, F_INC3
	} fill_op_t;

	typedef struct packed {
		logic     ld_in;
		logic     clr;
		logic     rd;
		logic     scan;
		logic     cap_j;
		ptr_op_t  ptr_op;
		wr_op_t   wr_op;
		fill_op_t fill_op;
		logic     st_ld;
		status_t  st_val;
		logic     emit;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		cond_t cond;
		step_t target;
		logic  stay;
	} ucode_t;

	typedef struct packed {
		logic zero_in;
		logic scan_end;
		logic not_found;
		logic full_ins;
		logic full_app;
		logic seek_zero;
		logic ptr_at_j;
	} flags_t;

	// cond false: stay in place when stay is set, else fall through
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t u;
		u = '0;
		unique case (step)
			S_IDLE: begin
				u.ctrl.ld_in = 1'b1;
				u.cond = C_START; u.target = S_CHKZ; u.stay = 1'b1;
			end
			S_CHKZ: begin
				u.ctrl.clr = 1'b1; u.ctrl.ptr_op = P_ZERO;
				u.cond = C_ZERO; u.target = S_REJ;
			end
			S_SCAN: begin
				u.ctrl.rd = 1'b1; u.ctrl.scan = 1'b1; u.ctrl.ptr_op = P_INC;
				u.cond = C_SCAN_END; u.target = S_DECIDE; u.stay = 1'b1;
			end
			S_DECIDE: begin
				u.ctrl.ptr_op = P_AT1;
				u.cond = C_NOT_FOUND; u.target = S_APP_CHK;
			end
			S_INS_CHK: begin
				u.cond = C_FULL_INS; u.target = S_FULL;
			end
			S_SEEK: begin
				u.ctrl.rd = 1'b1; u.ctrl.cap_j = 1'b1; u.ctrl.ptr_op = P_INC;
				u.cond = C_SEEK_ZERO; u.target = S_SH_INIT; u.stay = 1'b1;
			end
			S_SH_INIT: begin
				u.ctrl.ptr_op = P_LAST;
			end
			S_SHIFT: begin
				u.ctrl.rd = 1'b1; u.ctrl.ptr_op = P_DEC; u.ctrl.wr_op = W_SHIFT;
				u.cond = C_PTR_AT_J; u.target = S_SH_LAST; u.stay = 1'b1;
			end
			S_SH_LAST: begin
				u.ctrl.wr_op = W_SHIFT;
			end
			S_PUT_TS: begin
				u.ctrl.wr_op = W_TS_J; u.ctrl.fill_op = F_INC1;
				u.ctrl.st_ld = 1'b1; u.ctrl.st_val = ST_INS;
			end
			S_EMIT: begin
				u.ctrl.emit = 1'b1;
				u.cond = C_ALWAYS; u.target = S_IDLE;
			end
			S_APP_CHK: begin
				u.cond = C_FULL_APP; u.target = S_FULL;
			end
			S_APP_ID: begin
				u.ctrl.wr_op = W_ID;
			end
			S_APP_TS: begin
				u.ctrl.wr_op = W_TS;
			end
			S_APP_Z: begin
				u.ctrl.wr_op = W_ZERO; u.ctrl.fill_op = F_INC3;
				u.ctrl.st_ld = 1'b1; u.ctrl.st_val = ST_NEW;
				u.cond = C_ALWAYS; u.target = S_EMIT;
			end
			S_FULL: begin
				u.ctrl.st_ld = 1'b1; u.ctrl.st_val = ST_FULL;
				u.cond = C_ALWAYS; u.target = S_EMIT;
			end
			S_REJ: begin
				u.ctrl.st_ld = 1'b1; u.ctrl.st_val = ST_REJ;
				u.cond = C_ALWAYS; u.target = S_EMIT;
			end
			default: begin
				u.cond = C_ALWAYS; u.target = S_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage

FILE: src/perec_seq.sv
// ----------------------------------------------------------------------------
// perec_seq
// Step counter with ROM-driven conditional jumps; issues one control word.
// ----------------------------------------------------------------------------
module perec_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  perec_pkg::flags_t flags,
	output perec_pkg::ctrl_t  ctrl,
	output logic              busy
);

	perec_pkg::step_t  pc_q;
	perec_pkg::step_t  pc_d;
	perec_pkg::ucode_t uc;
	logic              cond_met;

	assign uc = perec_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (uc.cond)
			perec_pkg::C_NEVER:     cond_met = 1'b0;
			perec_pkg::C_ALWAYS:    cond_met = 1'b1;
			perec_pkg::C_START:     cond_met = start;
			perec_pkg::C_ZERO:      cond_met = flags.zero_in;
			perec_pkg::C_SCAN_END:  cond_met = flags.scan_end;
			perec_pkg::C_NOT_FOUND: cond_met = flags.not_found;
			perec_pkg::C_FULL_INS:  cond_met = flags.full_ins;
			perec_pkg::C_FULL_APP:  cond_met = flags.full_app;
			perec_pkg::C_SEEK_ZERO: cond_met = flags.seek_zero;
			perec_pkg::C_PTR_AT_J:  cond_met = flags.ptr_at_j;
			default:                cond_met = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		if (cond_met) begin
			pc_d = uc.target;
		end else if (uc.stay) begin
			pc_d = pc_q;
		end else begin
			pc_d = perec_pkg::step_t'(pc_q + 5'd1);
		end
	end

	// outputs
	always_comb begin
		ctrl = uc.ctrl;
		busy = (pc_q != perec_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= perec_pkg::S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

FILE: src/perec_dpath.sv
// ----------------------------------------------------------------------------
// perec_dpath
// Record store memory, pointer, fill count and result registers.
// ----------------------------------------------------------------------------
module perec_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  perec_pkg::ctrl_t              ctrl,
	input  logic [perec_pkg::WORD_W-1:0]  neighbor_id,
	input  logic [perec_pkg::WORD_W-1:0]  timestamp,
	output perec_pkg::flags_t             flags,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [perec_pkg::USED_W-1:0]  used_words
);

	logic [perec_pkg::WORD_W-1:0] mem [perec_pkg::CAPACITY];

	logic [perec_pkg::WORD_W-1:0] id_q;
	logic [perec_pkg::WORD_W-1:0] ts_q;
	logic [perec_pkg::CNT_W-1:0]  ptr_q;
	logic [perec_pkg::CNT_W-1:0]  fill_q;
	logic [perec_pkg::ADDR_W-1:0] at_q;
	logic [perec_pkg::ADDR_W-1:0] j_q;
	logic [perec_pkg::ADDR_W-1:0] addr_s1;
	logic [perec_pkg::WORD_W-1:0] rdata_s1;
	logic                         rd_vld_s1;
	logic                         prev_zero_q;
	logic                         found_q;
	logic                         done_q;
	perec_pkg::status_t           status_q;

	logic [perec_pkg::WORD_W-1:0] rdata;
	logic                         match;
	logic                         we;
	logic [perec_pkg::ADDR_W-1:0] wa;
	logic [perec_pkg::WORD_W-1:0] wd;
	logic [perec_pkg::ADDR_W-1:0] fill_a;

	// word 0 is the leading separator and is never written
	assign rdata  = (addr_s1 == '0) ? '0 : rdata_s1;
	assign match  = rd_vld_s1 && prev_zero_q && (rdata == id_q);
	assign fill_a = fill_q[perec_pkg::ADDR_W-1:0];

	always_comb begin
		flags.zero_in   = (id_q == '0) || (ts_q == '0);
		flags.scan_end  = rd_vld_s1 &&
			(match || (perec_pkg::CNT_W'(addr_s1) == fill_q - perec_pkg::CNT_W'(1)));
		flags.not_found = !found_q;
		flags.full_ins  = (fill_q >= perec_pkg::CNT_W'(perec_pkg::CAPACITY));
		flags.full_app  = (fill_q >= perec_pkg::CNT_W'(perec_pkg::CAPACITY - 2));
		flags.seek_zero = rd_vld_s1 && (rdata == '0);
		flags.ptr_at_j  = (ptr_q == perec_pkg::CNT_W'(j_q));
	end

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		case (ctrl.wr_op)
			perec_pkg::W_SHIFT: begin
				we = rd_vld_s1;
				wa = addr_s1 + perec_pkg::ADDR_W'(1);
				wd = rdata;
			end
			perec_pkg::W_TS_J: begin
				we = 1'b1; wa = j_q; wd = ts_q;
			end
			perec_pkg::W_ID: begin
				we = 1'b1; wa = fill_a; wd = id_q;
			end
			perec_pkg::W_TS: begin
				we = 1'b1; wa = fill_a + perec_pkg::ADDR_W'(1); wd = ts_q;
			end
			perec_pkg::W_ZERO: begin
				we = 1'b1; wa = fill_a + perec_pkg::ADDR_W'(2); wd = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ctrl.rd) begin
			rdata_s1 <= mem[ptr_q[perec_pkg::ADDR_W-1:0]];
			addr_s1  <= ptr_q[perec_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_in) begin
			id_q <= neighbor_id;
			ts_q <= timestamp;
		end
		if (ctrl.scan && match) begin
			at_q <= addr_s1;
		end
		if (ctrl.cap_j && rd_vld_s1 && (rdata == '0)) begin
			j_q <= addr_s1;
		end
		if (ctrl.st_ld) begin
			status_q <= ctrl.st_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			fill_q      <= perec_pkg::CNT_W'(1);
			rd_vld_s1   <= 1'b0;
			prev_zero_q <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_vld_s1 <= ctrl.rd;
			done_q    <= ctrl.emit;
			case (ctrl.ptr_op)
				perec_pkg::P_ZERO: ptr_q <= '0;
				perec_pkg::P_AT1:  ptr_q <= perec_pkg::CNT_W'(at_q) + perec_pkg::CNT_W'(1);
				perec_pkg::P_LAST: ptr_q <= fill_q - perec_pkg::CNT_W'(1);
				perec_pkg::P_INC:  ptr_q <= ptr_q + perec_pkg::CNT_W'(1);
				perec_pkg::P_DEC:  ptr_q <= ptr_q - perec_pkg::CNT_W'(1);
				default:           ptr_q <= ptr_q;
			endcase
			case (ctrl.fill_op)
				perec_pkg::F_INC1: fill_q <= fill_q + perec_pkg::CNT_W'(1);
				perec_pkg::F_INC3: fill_q <= fill_q + perec_pkg::CNT_W'(3);
				default:           fill_q <= fill_q;
			endcase
			if (ctrl.clr) begin
				prev_zero_q <= 1'b0;
				found_q     <= 1'b0;
			end else if (ctrl.scan && rd_vld_s1) begin
				prev_zero_q <= (rdata == '0);
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign used_words = perec_pkg::USED_W'(fill_q);

endmodule

FILE: src/packed_edge_record_insert.sv
// ----------------------------------------------------------------------------
// packed_edge_record_insert
// Insert-or-append of timestamps into a packed store of zero-separated
// neighbor records, run by a microcoded sequencer over one store port.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload                    direction
//  -------   -----------------   ------------------------   ---------
//  command   start / busy        neighbor_id, timestamp     in
//  result    done (1-cycle)      status, used_words         out
//
// A word is taken at a rising edge with start high and busy low; busy holds
// until done. The scan reads one store word per cycle. An insert seeks and
// shifts the tail after the match. The single store port sets this pace.
// Reset leaves one word in use and word 0 reads as the separator, so no
// clear pass runs; done is never stalled.
//
`include "packed_edge_record_insert_assert.svh"

module packed_edge_record_insert (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [15:0]                  neighbor_id,
	input  logic [15:0]                  timestamp,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [perec_pkg::USED_W-1:0] used_words
);

	perec_pkg::ctrl_t  ctrl;
	perec_pkg::flags_t flags;

	// step counter and microcode ROM
	perec_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// store, pointers, fill count, result registers
	perec_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.neighbor_id (neighbor_id),
		.timestamp   (timestamp),
		.flags       (flags),
		.done        (done),
		.status      (status),
		.used_words  (used_words)
	);

	// an accepted word holds off the next one
	`PEREC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised")

	// the strobe comes from the return to the idle step
	`PEREC_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "result while busy")

	// a new record takes three words, an added timestamp one
	`PEREC_ASSERT_SAME(a_new_grow, clk, arst_n, done && (status == perec_pkg::ST_NEW),
		used_words == perec_pkg::USED_W'($past(used_words, 2) + 13'd3), "bad append count")
	`PEREC_ASSERT_SAME(a_ins_grow, clk, arst_n, done && (status == perec_pkg::ST_INS),
		used_words == perec_pkg::USED_W'($past(used_words, 2) + 13'd1), "bad insert count")

endmodule

FILE: bench/packed_edge_record_insert_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_edge_record_insert_check
// Watches the command and result channels, keeps its own copy of the record
// store, predicts status and word count for every accepted word and compares.
// ----------------------------------------------------------------------------
module packed_edge_record_insert_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [15:0]                  neighbor_id,
	input  logic [15:0]                  timestamp,
	input  logic                         done,
	input  logic [1:0]                   status,
	input  logic [perec_pkg::USED_W-1:0] used_words,
	output int                           fail_count,
	output int                           pending
);

	typedef struct {
		perec_pkg::status_t           st;
		logic [perec_pkg::USED_W-1:0] used;
	} outcome_t;

	logic [perec_pkg::WORD_W-1:0] edge_words [perec_pkg::CAPACITY];
	int unsigned                  words_used;
	outcome_t                     pending_outcomes [$];

	// index of the id word of the first matching record, 0 when absent
	function automatic int unsigned locate_neighbor(input logic [15:0] id);
		int unsigned i;
		i = 0;
		while (i + 1 < words_used) begin
			if (edge_words[i] == '0) begin
				i++;
				if (edge_words[i] == id)
					return i;
			end
			i++;
		end
		return 0;
	endfunction

	function automatic outcome_t insert_outcome(input logic [15:0] id, input logic [15:0] ts);
		outcome_t    o;
		int unsigned at;
		int unsigned j;
		int unsigned k;
		if (id == '0 || ts == '0) begin
			o.st = perec_pkg::ST_REJ;
		end else begin
			at = locate_neighbor(id);
			if (at != 0) begin
				if (words_used + 1 > perec_pkg::CAPACITY) begin
					o.st = perec_pkg::ST_FULL;
				end else begin
					j = at;
					while (j < words_used && edge_words[j] != '0)
						j++;
					if (j >= words_used)
						j = words_used - 1;
					for (k = words_used; k > j; k--)
						edge_words[k] = edge_words[k - 1];
					edge_words[j] = ts;
					words_used++;
					o.st = perec_pkg::ST_INS;
				end
			end else if (words_used + 3 > perec_pkg::CAPACITY) begin
				o.st = perec_pkg::ST_FULL;
			end else begin
				edge_words[words_used]     = id;
				edge_words[words_used + 1] = ts;
				edge_words[words_used + 2] = '0;
				words_used += 3;
				o.st = perec_pkg::ST_NEW;
			end
		end
		o.used = words_used[perec_pkg::USED_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			words_used = 1;
			edge_words[0] = '0;
			pending_outcomes.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// result first: a new word may be taken at the edge that ends a result
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no word outstanding: status %0d used_words %0d",
						status, used_words);
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (used_words !== want.used) begin
						$error("used_words: expected %0d, got %0d", want.used, used_words);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				pending_outcomes.insert(pending_outcomes.size(),
					insert_outcome(neighbor_id, timestamp));
			pending <= pending_outcomes.size();
		end
	end

endmodule

FILE: bench/packed_edge_record_insert_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_edge_record_insert_test
// Drives neighbor/timestamp words into the record store block: a directed
// pass over rejects, new records and inserts, then a random pass that mixes
// idle gaps with back-to-back words. Checking is done by the checker
// instance; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module packed_edge_record_insert_test;

	// About 100 words are sent and the store stays below ~320 words.
	localparam int CYCLE_LIMIT = 500_000;
	localparam int TAIL_CYCLES = 16;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [15:0]                  neighbor_id;
	logic [15:0]                  timestamp;
	logic                         done;
	logic [1:0]                   status;
	logic [perec_pkg::USED_W-1:0] used_words;
	int                           fail_count;
	int                           pending;
	int                           cycles;
	bit                           burst;

	// ids that the directed pass leaves in the store; random words hit them
	// often so that most random words take the insert/shift path
	logic [15:0] known_ids [6] = '{16'h0001, 16'hFFFF, 16'h8000, 16'h5555,
		16'h0003, 16'h1234};

	packed_edge_record_insert u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.neighbor_id(neighbor_id),
		.timestamp  (timestamp),
		.done       (done),
		.status     (status),
		.used_words (used_words)
	);

	packed_edge_record_insert_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.neighbor_id(neighbor_id),
		.timestamp  (timestamp),
		.done       (done),
		.status     (status),
		.used_words (used_words),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Called just after a rising edge. Optional idle gap with start low, then
	// present the word and hold it until the edge where busy is low.
	// start stays high on return so a zero gap gives back-to-back words.
	task automatic send_word(input logic [15:0] id, input logic [15:0] ts, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		neighbor_id <= id;
		timestamp   <= ts;
		do @(posedge clk); while (busy);
	endtask

	// drop start and wait until every outstanding word has its result
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int draw_gap();
		return burst ? 0 : $urandom_range(19, 0);
	endfunction

	initial begin
		int          n;
		int          pick;
		logic [15:0] id;
		logic [15:0] ts;

		arst_n      = 1'b0;
		start       = 1'b0;
		neighbor_id = '0;
		timestamp   = '0;
		burst       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// zero values rejected on the empty store
		send_word(16'h0000, 16'h0000, draw_gap());
		send_word(16'h0000, 16'h0005, draw_gap());
		send_word(16'h0007, 16'h0000, draw_gap());
		// first record, then insert into it while it is the last record
		send_word(16'h0001, 16'h0001, draw_gap());
		send_word(16'h0001, 16'hFFFF, 0);
		// second record, then insert into the first: tail moves up one word
		send_word(16'hFFFF, 16'h0001, 0);
		send_word(16'h0001, 16'h0002, draw_gap());
		send_word(16'h8000, 16'hFFFF, draw_gap());
		// insert into a middle record
		send_word(16'hFFFF, 16'hFFFF, draw_gap());
		// a timestamp word equal to an id must not match in the scan
		send_word(16'h0003, 16'h1234, 0);
		send_word(16'h1234, 16'h0009, 0);
		send_word(16'h0000, 16'hFFFF, draw_gap());
		send_word(16'hFFFF, 16'h0000, draw_gap());
		send_word(16'h0001, 16'h5555, draw_gap());
		send_word(16'h0001, 16'hAAAA, 0);
		send_word(16'h5555, 16'hAAAA, draw_gap());
		send_word(16'h0003, 16'h8001, draw_gap());
		send_word(16'h1234, 16'h7FFE, 0);
		drain();

		// ---- random ----
		// mostly inserts into known records, some new records, a few rejects;
		// every 20 words the sender flips between gapped and back-to-back
		for (n = 0; n < 82; n++) begin
			if (n % 20 == 0)
				burst = ~burst;
			pick = $urandom_range(99, 0);
			if (pick < 8) begin
				id = $urandom_range(1, 0) ? 16'h0000 : 16'($urandom);
				ts = (id != '0 && $urandom_range(1, 0)) ? 16'h0000 : 16'($urandom);
				if (id != '0)
					ts = 16'h0000;
			end else if (pick < 70) begin
				id = known_ids[$urandom_range(5, 0)];
				ts = 16'($urandom);
			end else begin
				id = 16'($urandom);
				ts = 16'($urandom);
			end
			send_word(id, ts, draw_gap());
			// hold off once mid-run until the block has caught up
			if (n == 50)
				drain();
		end
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
